### hdl/sed_pkg.sv
package sed_pkg;

    // number formats
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;

    // trace magnitude and the divide-by-three pipeline
    localparam int TR_W        = 34;
    localparam int DIV_STEP    = 7;
    localparam int DIV_STAGES  = 5;
    localparam int DIV_W       = DIV_STAGES * DIV_STEP;

    // tensor entry magnitudes, their squares and the square sum
    localparam int MAG_W       = 34;
    localparam int SQ_W        = 67;
    localparam int Q_W         = 70;

    // square root pipeline, one result bit per stage
    localparam int ROOT_W      = 64;
    localparam int SQRT_STAGES = ROOT_W / 2;

    // pipeline bookkeeping
    localparam int MID_STAGES  = 5;
    localparam int P2_DLY      = DIV_STAGES + MID_STAGES + SQRT_STAGES;
    localparam int NVLD        = P2_DLY + 4;

    // register reset values
    localparam logic [DATA_W-1:0] COEF_RST = 32'd1311;
    localparam logic [DATA_W-1:0] CEIL_RST = 32'hFFFF_FFFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_COEF   = 2'd1,
        CFG_FLOOR  = 2'd2,
        CFG_CEIL   = 2'd3
    } t_cfg_idx;

endpackage

### hdl/sed_div3.sv
module sed_div3 (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sed_pkg::DIV_W-1:0]   i_num,
    output logic [sed_pkg::DIV_W-1:0]   o_quo
);

    logic [sed_pkg::DIV_W-1:0] r_num [sed_pkg::DIV_STAGES-1];
    logic [1:0]                r_rem [sed_pkg::DIV_STAGES-1];
    logic [sed_pkg::DIV_W-1:0] r_quo [sed_pkg::DIV_STAGES];
    logic [sed_pkg::DIV_W-1:0] n_quo [sed_pkg::DIV_STAGES];
    logic [1:0]                n_rem [sed_pkg::DIV_STAGES];

    genvar gs;
    generate
        for (gs = 0; gs < sed_pkg::DIV_STAGES; gs++) begin : g_stage
            logic [sed_pkg::DIV_W-1:0] num_in;
            logic [sed_pkg::DIV_W-1:0] quo_in;
            logic [1:0]                rem_in;

            if (gs == 0) begin : g_first
                assign num_in = i_num;
                assign quo_in = '0;
                assign rem_in = '0;
            end else begin : g_next
                assign num_in = r_num[gs-1];
                assign quo_in = r_quo[gs-1];
                assign rem_in = r_rem[gs-1];
            end

            // long division by three, DIV_STEP (seven) numerator bits per stage
            always_comb begin : p_step
                logic [2:0] v_t;
                logic [1:0] v_rem;
                v_rem = rem_in;
                n_quo[gs] = quo_in;
                for (int j = 0; j < sed_pkg::DIV_STEP; j++) begin
                    v_t = {v_rem, num_in[sed_pkg::DIV_W-1-gs*sed_pkg::DIV_STEP-j]};
                    if (v_t >= 3'd3) begin
                        n_quo[gs][sed_pkg::DIV_W-1-gs*sed_pkg::DIV_STEP-j] = 1'b1;
                        v_rem = 2'(v_t - 3'd3);
                    end else begin
                        n_quo[gs][sed_pkg::DIV_W-1-gs*sed_pkg::DIV_STEP-j] = 1'b0;
                        v_rem = v_t[1:0];
                    end
                end
                n_rem[gs] = v_rem;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[gs] <= n_quo[gs];
                end
            end

            if (gs < sed_pkg::DIV_STAGES - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_num[gs] <= num_in;
                        r_rem[gs] <= n_rem[gs];
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[sed_pkg::DIV_STAGES-1];

endmodule

### hdl/sed_isqrt.sv
module sed_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sed_pkg::ROOT_W-1:0]    i_n,
    output logic [sed_pkg::ROOT_W/2-1:0]  o_root
);

    logic [sed_pkg::ROOT_W-1:0] r_n   [sed_pkg::SQRT_STAGES-1];
    logic [sed_pkg::ROOT_W-1:0] r_res [sed_pkg::SQRT_STAGES];
    logic [sed_pkg::ROOT_W-1:0] n_n   [sed_pkg::SQRT_STAGES];
    logic [sed_pkg::ROOT_W-1:0] n_res [sed_pkg::SQRT_STAGES];

    genvar gs;
    generate
        for (gs = 0; gs < sed_pkg::SQRT_STAGES; gs++) begin : g_stage
            localparam logic [sed_pkg::ROOT_W-1:0] BIT =
                sed_pkg::ROOT_W'(1) << (sed_pkg::ROOT_W - 2 - 2 * gs);
            logic [sed_pkg::ROOT_W-1:0] n_in;
            logic [sed_pkg::ROOT_W-1:0] res_in;
            logic [sed_pkg::ROOT_W-1:0] trial;

            if (gs == 0) begin : g_first
                assign n_in   = i_n;
                assign res_in = '0;
            end else begin : g_next
                assign n_in   = r_n[gs-1];
                assign res_in = r_res[gs-1];
            end

            // one restoring step: try to take (res + bit) off the remainder
            assign trial = res_in + BIT;
            always_comb begin
                if (n_in >= trial) begin
                    n_n[gs]   = n_in - trial;
                    n_res[gs] = (res_in >> 1) + BIT;
                end else begin
                    n_n[gs]   = n_in;
                    n_res[gs] = res_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_res[gs] <= n_res[gs];
                end
            end

            if (gs < sed_pkg::SQRT_STAGES - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_n[gs] <= n_n[gs];
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_res[sed_pkg::SQRT_STAGES-1][sed_pkg::ROOT_W/2-1:0];

endmodule

### hdl/smagorinsky_eddy_diffusivity_unit.sv
// Smagorinsky eddy diffusivity, one cell per clock while the input is not
// stalled. Each transaction carries a 3x3 velocity gradient and a filter
// length in Q16.16 and returns the clamped diffusivity and the trace-free
// strain magnitude. The unit is a straight pipeline of 46 register stages:
// it takes a new cell every cycle unless the input is stalled. Most of that
// depth is the square root, which resolves one result bit per stage over 32
// stages; the divide by three of the trace takes five.
// A skid register at the output holds one result while the sink stalls, and
// the input is stalled only while that register is full. Registers are to be
// written through the configuration channel only while no cell is in flight;
// the user must keep to this, as the block itself does not enforce it.
module smagorinsky_eddy_diffusivity_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_grad_xx,
    input  logic [31:0] i_grad_xy,
    input  logic [31:0] i_grad_xz,
    input  logic [31:0] i_grad_yx,
    input  logic [31:0] i_grad_yy,
    input  logic [31:0] i_grad_yz,
    input  logic [31:0] i_grad_zx,
    input  logic [31:0] i_grad_zy,
    input  logic [31:0] i_grad_zz,
    input  logic [31:0] i_filter_length,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_diffusivity,
    output logic [31:0] o_strain_magnitude,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // truncating fixed-point product, saturated to 32 bits
    function automatic logic [31:0] qmul_sat(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        if (|p[63:sed_pkg::DATA_W+sed_pkg::FRAC_BITS]) begin
            return '1;
        end
        return p[sed_pkg::DATA_W+sed_pkg::FRAC_BITS-1:sed_pkg::FRAC_BITS];
    endfunction

    // magnitude of a signed tensor entry
    function automatic logic [sed_pkg::MAG_W-1:0] mag36(input logic signed [35:0] v);
        logic signed [35:0] a;
        a = (v < 0) ? -v : v;
        return a[sed_pkg::MAG_W-1:0];
    endfunction

    // configuration registers
    logic        r_enable;
    logic [31:0] r_coef;
    logic [31:0] r_floor;
    logic [31:0] r_ceil;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_coef   <= sed_pkg::COEF_RST;
            r_floor  <= '0;
            r_ceil   <= sed_pkg::CEIL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (sed_pkg::t_cfg_idx'(i_cfg_index))
                sed_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                sed_pkg::CFG_COEF:   r_coef   <= i_cfg_data;
                sed_pkg::CFG_FLOOR:  r_floor  <= i_cfg_data;
                sed_pkg::CFG_CEIL:   r_ceil   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance, held while the skid register is full
    logic                       r_sk_vld;
    logic                       en;
    logic [sed_pkg::NVLD-1:0]   r_vld;

    assign en      = !r_sk_vld;
    assign o_stall = r_sk_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[sed_pkg::NVLD-2:0], i_valid};
        end
    end

    // stage a: input capture
    logic signed [31:0] r_a_g [9];
    logic [31:0]        r_a_len;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_g[0] <= i_grad_xx;
            r_a_g[1] <= i_grad_xy;
            r_a_g[2] <= i_grad_xz;
            r_a_g[3] <= i_grad_yx;
            r_a_g[4] <= i_grad_yy;
            r_a_g[5] <= i_grad_yz;
            r_a_g[6] <= i_grad_zx;
            r_a_g[7] <= i_grad_zy;
            r_a_g[8] <= i_grad_zz;
            r_a_len  <= i_filter_length;
        end
    end

    // stage b: doubled symmetric tensor, trace, first length product
    logic signed [32:0] n_b_dd  [3];
    logic signed [32:0] n_b_off [3];
    logic signed [34:0] n_b_tr;
    logic signed [34:0] n_b_trabs;

    always_comb begin
        n_b_dd[0]  = $signed({r_a_g[0], 1'b0});
        n_b_dd[1]  = $signed({r_a_g[4], 1'b0});
        n_b_dd[2]  = $signed({r_a_g[8], 1'b0});
        n_b_off[0] = 33'(r_a_g[1]) + 33'(r_a_g[3]);
        n_b_off[1] = 33'(r_a_g[2]) + 33'(r_a_g[6]);
        n_b_off[2] = 33'(r_a_g[5]) + 33'(r_a_g[7]);
        n_b_tr     = 35'(n_b_dd[0]) + 35'(n_b_dd[1]) + 35'(n_b_dd[2]);
        n_b_trabs  = (n_b_tr < 0) ? -n_b_tr : n_b_tr;
    end

    logic signed [32:0]         r_b_dd  [3];
    logic signed [32:0]         r_b_off [3];
    logic                       r_b_neg;
    logic [sed_pkg::DIV_W-1:0]  r_b_trmag;
    logic [31:0]                r_b_p1;
    logic [31:0]                r_b_len;
    logic                       r_b_act;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_dd    <= n_b_dd;
            r_b_off   <= n_b_off;
            r_b_neg   <= n_b_tr < 0;
            r_b_trmag <= sed_pkg::DIV_W'(n_b_trabs[sed_pkg::TR_W-1:0]);
            r_b_p1    <= qmul_sat(r_coef, r_a_len);
            r_b_len   <= r_a_len;
            r_b_act   <= r_enable && (r_a_len != '0);
        end
    end

    // trace divided by three
    logic [sed_pkg::DIV_W-1:0] div_quo;

    sed_div3 u_div3 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_b_trmag),
        .o_quo (div_quo)
    );

    // tensor entries wait for the quotient
    logic signed [32:0] r_dl_dd  [sed_pkg::DIV_STAGES][3];
    logic signed [32:0] r_dl_off [sed_pkg::DIV_STAGES][3];
    logic               r_dl_neg [sed_pkg::DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_dd[0]  <= r_b_dd;
            r_dl_off[0] <= r_b_off;
            r_dl_neg[0] <= r_b_neg;
            for (int k = 1; k < sed_pkg::DIV_STAGES; k++) begin
                r_dl_dd[k]  <= r_dl_dd[k-1];
                r_dl_off[k] <= r_dl_off[k-1];
                r_dl_neg[k] <= r_dl_neg[k-1];
            end
        end
    end

    // second length product, then carried down to the final multiply
    logic [31:0] r_pd_p2  [sed_pkg::P2_DLY];
    logic        r_pd_act [sed_pkg::P2_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pd_p2[0]  <= qmul_sat(r_b_p1, r_b_len);
            r_pd_act[0] <= r_b_act;
            for (int k = 1; k < sed_pkg::P2_DLY; k++) begin
                r_pd_p2[k]  <= r_pd_p2[k-1];
                r_pd_act[k] <= r_pd_act[k-1];
            end
        end
    end

    // stage e: trace-free diagonal and entry magnitudes
    logic signed [34:0] e_third;
    logic signed [35:0] e_diag [3];

    always_comb begin
        e_third = r_dl_neg[sed_pkg::DIV_STAGES-1]
                ? -$signed({1'b0, div_quo[sed_pkg::TR_W-1:0]})
                :  $signed({1'b0, div_quo[sed_pkg::TR_W-1:0]});
        for (int k = 0; k < 3; k++) begin
            e_diag[k] = 36'(r_dl_dd[sed_pkg::DIV_STAGES-1][k]) - 36'(e_third);
        end
    end

    logic [sed_pkg::MAG_W-1:0] r_e_mag [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_e_mag[k]   <= mag36(e_diag[k]);
                r_e_mag[k+3] <= mag36(36'(r_dl_off[sed_pkg::DIV_STAGES-1][k]));
            end
        end
    end

    // stage f: partial products of each square
    logic [63:0] r_f_lo  [6];
    logic [33:0] r_f_mid [6];
    logic [3:0]  r_f_hh  [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                r_f_lo[k]  <= 64'(r_e_mag[k][31:0]) * 64'(r_e_mag[k][31:0]);
                r_f_mid[k] <= 34'(r_e_mag[k][sed_pkg::MAG_W-1:32]) * 34'(r_e_mag[k][31:0]);
                r_f_hh[k]  <= 4'(r_e_mag[k][sed_pkg::MAG_W-1:32])
                            * 4'(r_e_mag[k][sed_pkg::MAG_W-1:32]);
            end
        end
    end

    // stage g: assemble the squares
    logic [sed_pkg::SQ_W-1:0] r_g_sq [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                r_g_sq[k] <= sed_pkg::SQ_W'(r_f_lo[k])
                           + (sed_pkg::SQ_W'(r_f_mid[k]) << 33)
                           + (sed_pkg::SQ_W'(r_f_hh[k]) << 64);
            end
        end
    end

    // stage h: diagonal sum and doubled off-diagonal sum
    logic [sed_pkg::Q_W-1:0] r_h_dsum;
    logic [sed_pkg::Q_W-1:0] r_h_osum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_dsum <= sed_pkg::Q_W'(r_g_sq[0]) + sed_pkg::Q_W'(r_g_sq[1])
                      + sed_pkg::Q_W'(r_g_sq[2]);
            r_h_osum <= (sed_pkg::Q_W'(r_g_sq[3]) + sed_pkg::Q_W'(r_g_sq[4])
                       + sed_pkg::Q_W'(r_g_sq[5])) << 1;
        end
    end

    // stage i: halve the sum, saturate to the root width
    logic [sed_pkg::Q_W-1:0]    i_q;
    logic [sed_pkg::ROOT_W-1:0] r_i_n;

    assign i_q = r_h_dsum + r_h_osum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_n <= (|i_q[sed_pkg::Q_W-1:sed_pkg::ROOT_W+1]) ? '1
                   : i_q[sed_pkg::ROOT_W:1];
        end
    end

    // strain magnitude
    logic [31:0] strain;

    sed_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_n    (r_i_n),
        .o_root (strain)
    );

    // stage m: length product times strain
    logic [31:0] r_m_raw;
    logic [31:0] r_m_strain;
    logic        r_m_act;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_raw    <= qmul_sat(r_pd_p2[sed_pkg::P2_DLY-1], strain);
            r_m_strain <= strain;
            r_m_act    <= r_pd_act[sed_pkg::P2_DLY-1];
        end
    end

    // output stage: floor, then ceiling
    logic [31:0] m_lo;
    logic [31:0] m_clamp;

    always_comb begin
        m_lo    = (r_m_raw < r_floor) ? r_floor : r_m_raw;
        m_clamp = (m_lo > r_ceil) ? r_ceil : m_lo;
    end

    logic [31:0] r_o_diff;
    logic [31:0] r_o_strain;
    logic        r_o_act;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_diff   <= r_m_act ? m_clamp : '0;
            r_o_strain <= r_m_strain;
            r_o_act    <= r_m_act;
        end
    end

    // skid register catches the output stage when the sink stalls
    logic [31:0] r_sk_diff;
    logic [31:0] r_sk_strain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (!i_stall) begin
                r_sk_vld <= 1'b0;
            end
        end else if (r_vld[sed_pkg::NVLD-1] && i_stall) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_vld) begin
            r_sk_diff   <= r_o_diff;
            r_sk_strain <= r_o_strain;
        end
    end

    assign o_valid            = r_sk_vld || r_vld[sed_pkg::NVLD-1];
    assign o_diffusivity      = r_sk_vld ? r_sk_diff   : r_o_diff;
    assign o_strain_magnitude = r_sk_vld ? r_sk_strain : r_o_strain;

    // skid fills only on a stalled output transaction
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_vld) |-> $past(i_stall) && $past(r_vld[sed_pkg::NVLD-1]))
        else $error("skid filled without a stalled result");

    // a full skid freezes the pipeline
    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |=> r_vld == $past(r_vld))
        else $error("pipeline moved while skid was full");

    // an active result never exceeds the ceiling
    a_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[sed_pkg::NVLD-1] && !r_sk_vld && r_o_act) |-> r_o_diff <= r_ceil)
        else $error("diffusivity above ceiling");

endmodule

### sim/tb_smagorinsky_eddy_diffusivity_unit.sv
`timescale 1ns / 100ps

module tb_smagorinsky_eddy_diffusivity_unit;

    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [8:0][31:0] grad;
        logic [31:0]      len;
        bit               fixed;
        logic [31:0]      fix_diff;
        logic [31:0]      fix_strain;
    } t_cell_row;

    typedef struct {
        logic [31:0] diff;
        logic [31:0] strain;
    } t_eddy;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [8:0][31:0] grad_drv = '0;
    logic [31:0] i_filter_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_diffusivity;
    logic [31:0] o_strain_magnitude;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    sed_pkg::t_cfg_idx i_cfg_index = sed_pkg::CFG_ENABLE;
    logic [31:0] i_cfg_data = '0;

    // typed expectation riding along with the current transaction
    bit          fix_on = 1'b0;
    logic [31:0] fix_diff = '0;
    logic [31:0] fix_strain = '0;

    // mirror of the configuration registers
    logic        en_q = 1'b0;
    logic [31:0] coef_q = sed_pkg::COEF_RST;
    logic [31:0] floor_q = '0;
    logic [31:0] ceil_q = sed_pkg::CEIL_RST;

    t_eddy       pending_q[$];
    int          err_cnt = 0;
    int          idle_mode = 0;
    bit          hold_req = 1'b0;

    always #4 i_clk = ~i_clk;

    smagorinsky_eddy_diffusivity_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_grad_xx          (grad_drv[0]),
        .i_grad_xy          (grad_drv[1]),
        .i_grad_xz          (grad_drv[2]),
        .i_grad_yx          (grad_drv[3]),
        .i_grad_yy          (grad_drv[4]),
        .i_grad_yz          (grad_drv[5]),
        .i_grad_zx          (grad_drv[6]),
        .i_grad_zy          (grad_drv[7]),
        .i_grad_zz          (grad_drv[8]),
        .i_filter_length    (i_filter_length),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_diffusivity      (o_diffusivity),
        .o_strain_magnitude (o_strain_magnitude),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bval;
        res = '0;
        bval = 64'd1 << 62;
        while (bval > n) bval >>= 2;
        while (bval != 0) begin
            if (n >= res + bval) begin
                n -= res + bval;
                res = (res >> 1) + bval;
            end else begin
                res >>= 1;
            end
            bval >>= 2;
        end
        return res;
    endfunction

    // q16.16 product, truncated and saturated
    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = ({32'd0, a} * {32'd0, b}) >> sed_pkg::FRAC_BITS;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    // diffusivity and strain for one cell under the current registers
    function automatic t_eddy eddy_of(input logic [8:0][31:0] g, input logic [31:0] len);
        longint      d[3][3];
        longint      tr, third, m;
        logic [79:0] sumsq, half;
        logic [63:0] root;
        logic [31:0] dv;
        t_eddy       r;
        sumsq = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                d[i][j] = longint'($signed(g[i*3+j])) + longint'($signed(g[j*3+i]));
        tr = d[0][0] + d[1][1] + d[2][2];
        third = tr / 3;
        for (int i = 0; i < 3; i++) d[i][i] -= third;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                m = (d[i][j] < 0) ? -d[i][j] : d[i][j];
                sumsq += {16'd0, m} * {16'd0, m};
            end
        half = sumsq >> 1;
        root = isqrt(half[63:0]);
        if (half[79:64] != 0) r.strain = 32'hFFFF_FFFF;
        else r.strain = root[31:0];
        if (!en_q || len == 0) begin
            dv = '0;
        end else begin
            dv = qmul(qmul(qmul(coef_q, len), len), r.strain);
            if (dv < floor_q) dv = floor_q;
            if (dv > ceil_q) dv = ceil_q;
        end
        r.diff = dv;
        return r;
    endfunction

    // scoreboard: predict on input transaction, compare on output transaction
    always @(posedge i_clk) begin
        t_eddy e, got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (fix_on) begin
                    e.diff = fix_diff;
                    e.strain = fix_strain;
                end else begin
                    e = eddy_of(grad_drv, i_filter_length);
                end
                pending_q = {pending_q, e};
            end
            if (o_valid && !i_stall) begin
                got.diff = o_diffusivity;
                got.strain = o_strain_magnitude;
                if (pending_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected result diff=%h strain=%h",
                                                got.diff, got.strain);
                end else begin
                    e = pending_q.pop_front();
                    if (got.diff !== e.diff || got.strain !== e.strain) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: exp diff=%h strain=%h got diff=%h strain=%h",
                                     e.diff, e.strain, got.diff, got.strain);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sed_pkg::CFG_ENABLE: en_q <= i_cfg_data[0];
                    sed_pkg::CFG_COEF:   coef_q <= i_cfg_data;
                    sed_pkg::CFG_FLOOR:  floor_q <= i_cfg_data;
                    sed_pkg::CFG_CEIL:   ceil_q <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // output side stall, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            i_stall = 1'b1;
            for (int c = 0; c < 300; c++) @(negedge i_clk);
            hold_req = 1'b0;
            i_stall = 1'b0;
        end else begin
            case (idle_mode)
                2:       i_stall = ($urandom_range(99) < 77);
                3:       i_stall = ($urandom_range(99) < 18);
                default: i_stall = 1'b0;
            endcase
        end
    end

    // drive one cell, called at a falling edge and returning at one
    task automatic send_cell(input t_cell_row row);
        int gap;
        gap = (idle_mode == 1) ? 77 : (idle_mode == 3) ? 18 : 0;
        while ($urandom_range(99) < gap) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        grad_drv = row.grad;
        i_filter_length = row.len;
        fix_on = row.fixed;
        fix_diff = row.fix_diff;
        fix_strain = row.fix_strain;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait for every result, then let the pipeline empty
    task automatic drain();
        i_valid = 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(input sed_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return $urandom_range(65535) - 32768;
            default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic t_cell_row rand_cell();
        t_cell_row r;
        for (int k = 0; k < 9; k++) r.grad[k] = rand_grad();
        case ($urandom_range(7))
            0:       r.len = '0;
            1:       r.len = $urandom();
            2:       r.len = 32'hFFFF_FFFF;
            default: r.len = $urandom_range(32'h0040_0000, 32'h0000_1000);
        endcase
        r.fixed = 1'b0;
        r.fix_diff = '0;
        r.fix_strain = '0;
        return r;
    endfunction

    function automatic t_cell_row mk(input logic [8:0][31:0] g, input logic [31:0] len,
                                     input bit fixed, input logic [31:0] fd,
                                     input logic [31:0] fs);
        t_cell_row r;
        r.grad = g;
        r.len = len;
        r.fixed = fixed;
        r.fix_diff = fd;
        r.fix_strain = fs;
        return r;
    endfunction

    initial begin
        t_cell_row   dir_tbl[$];
        logic [31:0] cfg_tbl[7][4];
        t_cell_row   r;

        // directed cells, run with registers at reset (diffusion off)
        dir_tbl = {dir_tbl, mk('0, 32'h0001_0000, 1, 0, 0)};
        dir_tbl = {dir_tbl, mk({9{32'h0001_0000}}, 32'h0001_0000, 1'b0, 0, 0)};
        dir_tbl = {dir_tbl, mk({32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                                32'h0, 32'h0, 32'h0, 32'h0001_0000}, 32'h0001_0000, 1, 0, 0)};
        dir_tbl = {dir_tbl, mk({224'h0, 32'h0001_0000, 32'h0}, 32'h0, 1, 0, 32'h0001_0000)};
        dir_tbl = {dir_tbl, mk({9{32'h7FFF_FFFF}}, 32'hFFFF_FFFF, 1'b0, 0, 0)};
        dir_tbl = {dir_tbl, mk({9{32'h8000_0000}}, 32'hFFFF_FFFF, 1'b0, 0, 0)};
        dir_tbl = {dir_tbl, mk({9{32'hFFFF_FFFF}}, 32'h0000_0001, 1'b0, 0, 0)};
        dir_tbl = {dir_tbl, mk({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                               32'h8000_0000, 1'b0, 0, 0)};
        dir_tbl = {dir_tbl, mk({32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                                160'h0}, 32'h0001_0000, 1'b0, 0, 0)};
        dir_tbl = {dir_tbl, mk({32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000,
                                32'h0, 32'h0, 32'h0, 32'h0}, 32'h0002_0000, 1'b0, 0, 0)};
        dir_tbl = {dir_tbl, mk({32'hFFFD_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                                32'h0, 32'h0, 32'h0, 32'h0000_0001}, 32'h0002_0000,
                               1'b0, 0, 0)};

        // enable, coefficient, floor, ceiling per random phase
        cfg_tbl[0] = '{32'd1, sed_pkg::COEF_RST, 32'h0, sed_pkg::CEIL_RST};
        cfg_tbl[1] = '{32'd1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        cfg_tbl[2] = '{32'd1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        cfg_tbl[3] = '{32'd1, 32'h0001_0000, 32'h0005_0000, 32'h0002_0000};
        cfg_tbl[4] = '{32'd0, 32'h0000_8000, 32'h0000_0100, 32'h0010_0000};
        cfg_tbl[5] = '{32'd1, 32'h0000_2000, 32'h0000_0040, 32'h0400_0000};
        cfg_tbl[6] = '{32'd1, sed_pkg::COEF_RST, 32'h0, 32'h0};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[k]) send_cell(dir_tbl[k]);
        drain();

        // random phases, each under its own register setting and one of four idling modes
        for (int ph = 0; ph < 7; ph++) begin
            reg_write(sed_pkg::CFG_ENABLE, cfg_tbl[ph][0]);
            reg_write(sed_pkg::CFG_COEF, (ph == 5) ? $urandom() : cfg_tbl[ph][1]);
            reg_write(sed_pkg::CFG_FLOOR, cfg_tbl[ph][2]);
            reg_write(sed_pkg::CFG_CEIL, cfg_tbl[ph][3]);
            idle_mode = ph % 4;
            if (ph == 0) hold_req = 1'b1;
            for (int n = 0; n < 120; n++) begin
                r = rand_cell();
                send_cell(r);
            end
            drain();
        end

        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #6000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/sed_pkg.sv
hdl/sed_div3.sv
hdl/sed_isqrt.sv
hdl/smagorinsky_eddy_diffusivity_unit.sv
sim/tb_smagorinsky_eddy_diffusivity_unit.sv
